>>> hdl/tcrs_pkg.sv
// ----------------------------------------------------------------------------
// tcrs_pkg
// Shared types and constants of the three-class runway scheduler.
// ----------------------------------------------------------------------------
package tcrs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;
    localparam int FIELD_ID_W      = 16;
    localparam int CFG_DATA_W      = 5;

    localparam logic [1:0] MODE_EMER  = 2'd0;
    localparam logic [1:0] MODE_LAND  = 2'd1;
    localparam logic [1:0] MODE_TAKE  = 2'd2;
    localparam logic [1:0] MODE_GRANT = 2'd3;

    localparam logic [1:0] CLS_EMER = 2'd0;
    localparam logic [1:0] CLS_LAND = 2'd1;
    localparam logic [1:0] CLS_TAKE = 2'd2;

    localparam logic [1:0] ST_QUEUED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_GRANTED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [1:0] POL_LAND_FIRST = 2'd0;
    localparam logic [1:0] POL_THRESHOLD  = 2'd1;
    localparam logic [1:0] POL_EMER_THR   = 2'd2;
    localparam logic [1:0] POL_EMER_AGED  = 2'd3;

    localparam logic REG_POLICY    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [1:0] POLICY_RST    = POL_EMER_AGED;
    localparam logic [4:0] THRESHOLD_RST = 5'd5;

    localparam logic [7:0] LAND_START_PRIO = 8'd5;
    localparam logic [7:0] TAKE_START_PRIO = 8'd1;
    localparam logic [7:0] PRIO_MAX        = 8'd255;

    typedef struct packed {
        logic load;
        logic arrive;
        logic head_rd;
        logic grant;
        logic age_rd;
        logic age_wr;
    } t_ctrl;

    typedef struct packed {
        logic age;
        logic sweep_last;
    } t_stat;

endpackage

>>> hdl/tcrs_ctrl.sv
// ----------------------------------------------------------------------------
// tcrs_ctrl
// Sequencer: arrival, head read, grant decision and priority aging sweep.
// ----------------------------------------------------------------------------
module tcrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_grant,
    input  tcrs_pkg::t_stat i_stat,
    output tcrs_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARRIVE,
        S_HEAD_RD,
        S_GRANT,
        S_AGE_RD,
        S_AGE_WR
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_grant ? S_HEAD_RD : S_ARRIVE;
                end
            end
            S_ARRIVE:  n_state = S_IDLE;
            S_HEAD_RD: n_state = S_GRANT;
            S_GRANT:   n_state = i_stat.age ? S_AGE_RD : S_IDLE;
            S_AGE_RD:  n_state = S_AGE_WR;
            S_AGE_WR:  n_state = i_stat.sweep_last ? S_IDLE : S_AGE_RD;
            default:   n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.load    = (r_state == S_IDLE) && i_start;
        o_ctrl.arrive  = (r_state == S_ARRIVE);
        o_ctrl.head_rd = (r_state == S_HEAD_RD);
        o_ctrl.grant   = (r_state == S_GRANT);
        o_ctrl.age_rd  = (r_state == S_AGE_RD);
        o_ctrl.age_wr  = (r_state == S_AGE_WR);
    end

    assign o_busy = r_busy;

endmodule

>>> hdl/tcrs_datapath.sv
// ----------------------------------------------------------------------------
// tcrs_datapath
// Queue memories, pointers, configuration, grant choice and result registers.
// ----------------------------------------------------------------------------
module tcrs_datapath #(
    parameter int QUEUE_DEPTH = tcrs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = tcrs_pkg::ID_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcrs_pkg::t_ctrl                 i_ctrl,
    output tcrs_pkg::t_stat                 o_stat,
    input  logic [1:0]                      i_mode,
    input  logic [tcrs_pkg::FIELD_ID_W-1:0] i_requester_id,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [tcrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [1:0]                      o_granted_class,
    output logic [tcrs_pkg::FIELD_ID_W-1:0] o_granted_id
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = (ID_WIDTH < tcrs_pkg::FIELD_ID_W) ? ID_WIDTH : tcrs_pkg::FIELD_ID_W;
    localparam int TW = (CW > tcrs_pkg::CFG_DATA_W) ? CW : tcrs_pkg::CFG_DATA_W;
    localparam logic [CW-1:0] FULL     = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    logic [KW-1:0] r_emer_ids [QUEUE_DEPTH];
    logic [KW-1:0] r_land_ids [QUEUE_DEPTH];
    logic [KW-1:0] r_take_ids [QUEUE_DEPTH];
    logic [7:0]    r_land_prio [QUEUE_DEPTH];
    logic [7:0]    r_take_prio [QUEUE_DEPTH];

    logic [AW-1:0] r_head  [3];
    logic [CW-1:0] r_count [3];
    logic [1:0]    r_policy;
    logic [4:0]    r_thresh;
    logic [1:0]    r_mode;
    logic [KW-1:0] r_id;
    logic [AW-1:0] r_sweep;

    logic [KW-1:0] r_rd_eid, r_rd_lid, r_rd_tid;
    logic [7:0]    r_rd_pl, r_rd_pt;

    logic          r_valid;
    logic [1:0]    r_status, r_class;
    logic [KW-1:0] r_gid;

    // arrival side
    logic [AW-1:0] sel_head;
    logic [CW-1:0] sel_count;
    logic [CW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic          full, push;

    always_comb begin
        unique case (r_mode)
            tcrs_pkg::MODE_EMER: begin sel_head = r_head[0]; sel_count = r_count[0]; end
            tcrs_pkg::MODE_LAND: begin sel_head = r_head[1]; sel_count = r_count[1]; end
            default:             begin sel_head = r_head[2]; sel_count = r_count[2]; end
        endcase
        tail_sum = (CW+1)'(sel_head) + (CW+1)'(sel_count);
        tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                   AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
        full     = (sel_count == FULL);
        push     = i_ctrl.arrive && !full;
    end

    // grant choice
    logic          ne, nl, nt, none, age;
    logic [1:0]    pick;
    logic [TW-1:0] nt_x, thr_x;

    always_comb begin
        ne    = (r_count[0] != '0);
        nl    = (r_count[1] != '0);
        nt    = (r_count[2] != '0);
        nt_x  = TW'(r_count[2]);
        thr_x = TW'(r_thresh);
        none  = 1'b0;
        age   = 1'b0;
        pick  = tcrs_pkg::CLS_LAND;
        priority if (((r_policy == tcrs_pkg::POL_EMER_THR) ||
                      (r_policy == tcrs_pkg::POL_EMER_AGED)) && ne) begin
            pick = tcrs_pkg::CLS_EMER;
        end else if (!nl && !nt) begin
            none = 1'b1;
        end else if (!nl) begin
            pick = tcrs_pkg::CLS_TAKE;
        end else if (!nt) begin
            pick = tcrs_pkg::CLS_LAND;
        end else if (r_policy == tcrs_pkg::POL_LAND_FIRST) begin
            pick = tcrs_pkg::CLS_LAND;
        end else if (r_policy != tcrs_pkg::POL_EMER_AGED) begin
            pick = (nt_x >= thr_x) ? tcrs_pkg::CLS_TAKE : tcrs_pkg::CLS_LAND;
        end else begin
            age  = 1'b1;
            pick = ((r_rd_pt > r_rd_pl) ||
                    ((r_rd_pt == r_rd_pl) && (r_count[2] > r_count[1]))) ?
                   tcrs_pkg::CLS_TAKE : tcrs_pkg::CLS_LAND;
        end
    end

    assign o_stat.age        = i_ctrl.grant && age;
    assign o_stat.sweep_last = (r_sweep == LAST_IDX);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= tcrs_pkg::POLICY_RST;
            r_thresh <= tcrs_pkg::THRESHOLD_RST;
            r_valid  <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
            r_sweep <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tcrs_pkg::REG_POLICY:    r_policy <= i_cfg_data[1:0];
                    tcrs_pkg::REG_THRESHOLD: r_thresh <= i_cfg_data;
                    default: ;
                endcase
            end
            r_valid <= i_ctrl.arrive || i_ctrl.grant;
            for (int c = 0; c < 3; c++) begin
                if (push && (r_mode == 2'(c))) begin
                    r_count[c] <= r_count[c] + 1'b1;
                end
                if (i_ctrl.grant && !none && (pick == 2'(c))) begin
                    r_count[c] <= r_count[c] - 1'b1;
                    r_head[c]  <= (r_head[c] == LAST_IDX) ? '0 : r_head[c] + 1'b1;
                end
            end
            if (i_ctrl.grant) begin
                r_sweep <= '0;
            end else if (i_ctrl.age_wr) begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mode <= i_mode;
            r_id   <= i_requester_id[KW-1:0];
        end
        if (i_ctrl.arrive) begin
            r_status <= full ? tcrs_pkg::ST_DROPPED : tcrs_pkg::ST_QUEUED;
            r_class  <= '0;
            r_gid    <= '0;
        end else if (i_ctrl.grant) begin
            if (none) begin
                r_status <= tcrs_pkg::ST_EMPTY;
                r_class  <= '0;
                r_gid    <= '0;
            end else begin
                r_status <= tcrs_pkg::ST_GRANTED;
                r_class  <= pick;
                unique case (pick)
                    tcrs_pkg::CLS_EMER: r_gid <= r_rd_eid;
                    tcrs_pkg::CLS_LAND: r_gid <= r_rd_lid;
                    default:            r_gid <= r_rd_tid;
                endcase
            end
        end
    end

    // id memories
    always_ff @(posedge i_clk) begin
        if (push && (r_mode == tcrs_pkg::MODE_EMER)) r_emer_ids[tail] <= r_id;
        if (push && (r_mode == tcrs_pkg::MODE_LAND)) r_land_ids[tail] <= r_id;
        if (push && (r_mode == tcrs_pkg::MODE_TAKE)) r_take_ids[tail] <= r_id;
        if (i_ctrl.head_rd) begin
            r_rd_eid <= r_emer_ids[r_head[0]];
            r_rd_lid <= r_land_ids[r_head[1]];
            r_rd_tid <= r_take_ids[r_head[2]];
        end
    end

    // priority memories: head read for grant, read-modify-write sweep for aging
    logic          lp_we, tp_we;
    logic [AW-1:0] lp_wa, tp_wa, lp_ra, tp_ra;
    logic [7:0]    lp_wd, tp_wd;

    always_comb begin
        lp_we = i_ctrl.age_wr || (push && (r_mode == tcrs_pkg::MODE_LAND));
        tp_we = i_ctrl.age_wr || (push && (r_mode == tcrs_pkg::MODE_TAKE));
        lp_wa = i_ctrl.age_wr ? r_sweep : tail;
        tp_wa = i_ctrl.age_wr ? r_sweep : tail;
        lp_wd = !i_ctrl.age_wr ? tcrs_pkg::LAND_START_PRIO :
                (r_rd_pl == tcrs_pkg::PRIO_MAX) ? r_rd_pl : r_rd_pl + 8'd1;
        tp_wd = !i_ctrl.age_wr ? tcrs_pkg::TAKE_START_PRIO :
                (r_rd_pt == tcrs_pkg::PRIO_MAX) ? r_rd_pt : r_rd_pt + 8'd1;
        lp_ra = i_ctrl.age_rd ? r_sweep : r_head[1];
        tp_ra = i_ctrl.age_rd ? r_sweep : r_head[2];
    end

    always_ff @(posedge i_clk) begin
        if (lp_we) r_land_prio[lp_wa] <= lp_wd;
        if (tp_we) r_take_prio[tp_wa] <= tp_wd;
        if (i_ctrl.head_rd || i_ctrl.age_rd) begin
            r_rd_pl <= r_land_prio[lp_ra];
            r_rd_pt <= r_take_prio[tp_ra];
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_granted_class = r_class;
    assign o_granted_id    = tcrs_pkg::FIELD_ID_W'(r_gid);

endmodule

>>> hdl/three_class_runway_scheduler_with_aging.sv
// ----------------------------------------------------------------------------
// three_class_runway_scheduler_with_aging
// Emergency, landing and takeoff request queues with policy-driven grants.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item gives one
// result, shown for one cycle with o_valid; it cannot be held off. An arrival
// passes through ARRIVE, a grant slot through HEAD_RD and GRANT. A grant under
// the aged-priority policy with landing and takeoff waiting and no emergency
// also ages every priority slot by a read-modify-write sweep over the priority
// memories, AGE_RD then AGE_WR per slot. Configuration writes take effect at
// once and are meant for idle periods.
module three_class_runway_scheduler_with_aging #(
    parameter int QUEUE_DEPTH = tcrs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = tcrs_pkg::ID_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_mode,
    input  logic [tcrs_pkg::FIELD_ID_W-1:0] i_requester_id,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [tcrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [1:0]                      o_granted_class,
    output logic [tcrs_pkg::FIELD_ID_W-1:0] o_granted_id
);

    tcrs_pkg::t_ctrl ctrl;
    tcrs_pkg::t_stat stat;

    tcrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_grant (i_mode == tcrs_pkg::MODE_GRANT),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    tcrs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_requester_id  (i_requester_id),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_granted_class (o_granted_class),
        .o_granted_id    (o_granted_id)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result transfers in a row");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without an item in progress");

    a_nongrant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != tcrs_pkg::ST_GRANTED) |->
            (o_granted_class == 2'd0) && (o_granted_id == '0))
        else $error("non-grant result carries class or id");

endmodule
